@@ hdl/ipnmf_pkg.sv @@
// shared constants and types for the invalid pixel neighbour mean fill block
`default_nettype none

package ipnmf_pkg;

   localparam int WIDTH_REG_BITS  = 12;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WIDTH     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HEIGHT    = 2'd2;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd2048;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd2;

   // 3x3 window, row-major taps, centre in the middle
   localparam int NUM_TAPS   = 9;
   localparam int CENTRE_TAP = 4;
   localparam int COUNT_BITS = 4;

   typedef struct packed {
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
      logic last;
   } border_type;

endpackage

`default_nettype wire

@@ hdl/ipnmf_ifs.sv @@
// handshake channel interfaces: pixel input, result output, register writes
`default_nettype none

interface ipnmf_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          drain;

   modport source (output valid, sample, drain, input ready);
   modport sink (input valid, sample, drain, output ready);
endinterface

interface ipnmf_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] filled_value;
   logic                          was_replaced;
   logic                          frame_last;

   modport source (output valid, filled_value, was_replaced, frame_last, input ready);
   modport sink (input valid, filled_value, was_replaced, frame_last, output ready);
endinterface

interface ipnmf_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ipnmf_pkg::CSR_INDEX_BITS-1:0] index;
   logic [ipnmf_pkg::CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ hdl/ipnmf_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module ipnmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/ipnmf_mean.sv @@
// neighbour sum, reciprocal divide by the valid count and result register
`default_nettype none

module ipnmf_mean #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [SAMPLE_BITS-1:0] win [ipnmf_pkg::NUM_TAPS],
   input  wire ipnmf_pkg::border_type         border,
   input  wire logic signed [SAMPLE_BITS-1:0] threshold,
   output logic                               busy,
   ipnmf_rsp_if.source                        rsp_ch
);

   localparam int SUMW  = SAMPLE_BITS + 3;
   localparam int KSH   = SUMW;
   localparam int RBITS = KSH + 1;
   localparam int CW    = ipnmf_pkg::COUNT_BITS;

   // floor(2^KSH / d); quotient from it is exact or one short
   localparam logic [RBITS-1:0] RECIP [ipnmf_pkg::NUM_TAPS] = '{
      RBITS'(0),
      RBITS'((64'd1 << KSH) / 64'd1),
      RBITS'((64'd1 << KSH) / 64'd2),
      RBITS'((64'd1 << KSH) / 64'd3),
      RBITS'((64'd1 << KSH) / 64'd4),
      RBITS'((64'd1 << KSH) / 64'd5),
      RBITS'((64'd1 << KSH) / 64'd6),
      RBITS'((64'd1 << KSH) / 64'd7),
      RBITS'((64'd1 << KSH) / 64'd8)
   };

   // sum stage
   logic signed [SUMW-1:0]        sum_c;
   logic        [CW-1:0]          cnt_c;
   logic                          repl_c;
   logic                          tap_row_ok;
   logic                          tap_col_ok;

   logic                          v1_ff;
   logic        [SUMW-1:0]        mag1_ff;
   logic                          neg1_ff;
   logic        [CW-1:0]          cnt1_ff;
   logic                          repl1_ff;
   logic signed [SAMPLE_BITS-1:0] centre1_ff;
   logic                          last1_ff;

   // multiply stage
   logic        [SUMW+RBITS-1:0]  prod_c;

   logic                          v2_ff;
   logic                          v2_in;
   logic        [SUMW-1:0]        q0_ff;
   logic        [SUMW-1:0]        mag2_ff;
   logic                          neg2_ff;
   logic        [CW-1:0]          cnt2_ff;
   logic                          repl2_ff;
   logic signed [SAMPLE_BITS-1:0] centre2_ff;
   logic                          last2_ff;

   // correction stage and result register
   logic        [SUMW+CW-1:0]     back_c;
   logic        [SUMW-1:0]        rem_c;
   logic        [SUMW-1:0]        q_c;
   logic signed [SAMPLE_BITS-1:0] value_c;
   logic                          fix_go;

   logic                          out_v_ff;
   logic                          out_v_in;
   logic signed [SAMPLE_BITS-1:0] out_value_ff;
   logic                          out_repl_ff;
   logic                          out_last_ff;

   always_comb begin
      sum_c = '0;
      cnt_c = '0;
      tap_row_ok = 1'b0;
      tap_col_ok = 1'b0;
      for (int i = 0; i < ipnmf_pkg::NUM_TAPS; i++) begin
         tap_row_ok = (i < 3) ? border.top_ok : ((i >= 6) ? border.bot_ok : 1'b1);
         tap_col_ok = ((i % 3) == 0) ? border.left_ok :
                      (((i % 3) == 2) ? border.right_ok : 1'b1);
         if (i != ipnmf_pkg::CENTRE_TAP && tap_row_ok && tap_col_ok &&
             win[i] <= threshold) begin
            sum_c = sum_c + SUMW'(win[i]);
            cnt_c = cnt_c + CW'(1);
         end
      end
      repl_c = (win[ipnmf_pkg::CENTRE_TAP] > threshold) && (cnt_c != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag1_ff    <= sum_c[SUMW-1] ? SUMW'(-sum_c) : SUMW'(sum_c);
         neg1_ff    <= sum_c[SUMW-1];
         cnt1_ff    <= cnt_c;
         repl1_ff   <= repl_c;
         centre1_ff <= win[ipnmf_pkg::CENTRE_TAP];
         last1_ff   <= border.last;
      end
   end

   assign prod_c = (SUMW+RBITS)'(mag1_ff) * (SUMW+RBITS)'(RECIP[cnt1_ff]);

   // v1 is only set while v2 is empty, so the multiply never waits
   assign v2_in = v1_ff ? 1'b1 : (fix_go ? 1'b0 : v2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         q0_ff      <= prod_c[KSH +: SUMW];
         mag2_ff    <= mag1_ff;
         neg2_ff    <= neg1_ff;
         cnt2_ff    <= cnt1_ff;
         repl2_ff   <= repl1_ff;
         centre2_ff <= centre1_ff;
         last2_ff   <= last1_ff;
      end
   end

   always_comb begin
      back_c = (SUMW+CW)'(q0_ff) * (SUMW+CW)'(cnt2_ff);
      rem_c  = mag2_ff - back_c[SUMW-1:0];
      q_c    = (rem_c >= SUMW'(cnt2_ff)) ? q0_ff + SUMW'(1) : q0_ff;
      if (repl2_ff) begin
         value_c = neg2_ff ? SAMPLE_BITS'(-q_c) : SAMPLE_BITS'(q_c);
      end else begin
         value_c = centre2_ff;
      end
   end

   assign fix_go   = v2_ff && (!out_v_ff || rsp_ch.ready);
   assign out_v_in = fix_go ? 1'b1 : ((out_v_ff && rsp_ch.ready) ? 1'b0 : out_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fix_go) begin
         out_value_ff <= value_c;
         out_repl_ff  <= repl2_ff;
         out_last_ff  <= last2_ff;
      end
   end

   assign busy                = v1_ff || v2_ff;
   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.filled_value = out_value_ff;
   assign rsp_ch.was_replaced = out_repl_ff;
   assign rsp_ch.frame_last   = out_last_ff;

endmodule

`default_nettype wire

@@ hdl/invalid_pixel_neighbour_mean_fill.sv @@
// top level: registers, scan counters, line store and 3x3 window feeding the mean unit
//
//   channel  role    word                                       handshake
//   req_ch   in      sample, drain                              valid / ready
//   rsp_ch   out     filled_value, was_replaced, frame_last     valid / ready
//   csr_ch   in      index, wdata (0 threshold, 1 width, 2 ht)  valid / ready (always ready)
//
// an item with a result passes, in order: accept with line store read, window update
// with write-back, neighbour sum, reciprocal multiply, correction into the result
// register; with no result it ends after the window update, and a drain ignored inside
// the frame at accept. the read-modify-write and the single-item mean unit hold off input.
// reset clears counters and window; the line store is not cleared, border masking
// hides rows not yet written. a result waiting in the output register blocks only
// the next result, not the next input word.
`default_nettype none

module invalid_pixel_neighbour_mean_fill #(
   parameter int MAX_WIDTH   = 2048,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ipnmf_req_if.sink   req_ch,
   ipnmf_rsp_if.source rsp_ch,
   ipnmf_csr_if.sink   csr_ch
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > ipnmf_pkg::WIDTH_REG_BITS) ? CW + 1 :
                       ipnmf_pkg::WIDTH_REG_BITS;
   localparam int HB = ipnmf_pkg::HEIGHT_REG_BITS;
   localparam int RW = HB + 1;
   localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LOAD = 1'b1;

   // registers
   logic signed [SAMPLE_BITS-1:0]             thresh_ff;
   logic        [ipnmf_pkg::WIDTH_REG_BITS-1:0] width_reg_ff;
   logic        [HB-1:0]                      height_reg_ff;

   logic                          state_ff;
   logic                          state_in;
   logic        [CW-1:0]          in_col_ff;
   logic        [CW-1:0]          in_col_in;
   logic        [RW-1:0]          in_row_ff;
   logic        [RW-1:0]          in_row_in;
   logic        [CW-1:0]          out_col_ff;
   logic        [CW-1:0]          out_col_in;
   logic        [HB-1:0]          out_row_ff;
   logic        [HB-1:0]          out_row_in;
   logic signed [SAMPLE_BITS-1:0] s_ff;
   logic signed [SAMPLE_BITS-1:0] win_ff [ipnmf_pkg::NUM_TAPS];
   ipnmf_pkg::border_type         border_ff;
   ipnmf_pkg::border_type         border_c;
   logic                          start_ff;
   logic                          start_in;

   // effective geometry and scan logic
   logic        [WW-1:0]          w_raw;
   logic        [WW-1:0]          w_eff;
   logic        [HB-1:0]          h_eff;
   logic        [RW-1:0]          h_ext;
   logic        [WW-1:0]          in_col_inc;
   logic        [WW-1:0]          out_col_inc;
   logic        [RW-1:0]          out_row_inc;
   logic        [RW-1:0]          out_row_n;
   logic                          in_wrap;
   logic                          out_wrap;
   logic                          emit;
   logic                          accept;
   logic                          skip;
   logic                          blank;
   logic                          mean_busy;
   logic                          loading;

   // line store: per column {row above previous, previous row}
   logic [2*SAMPLE_BITS-1:0]      ram_rd_data;
   logic signed [SAMPLE_BITS-1:0] top_c;
   logic signed [SAMPLE_BITS-1:0] mid_c;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         width_reg_ff  <= ipnmf_pkg::WIDTH_RESET;
         height_reg_ff <= ipnmf_pkg::HEIGHT_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ipnmf_pkg::REG_THRESHOLD: thresh_ff <= csr_ch.wdata[SAMPLE_BITS-1:0];
            ipnmf_pkg::REG_WIDTH: width_reg_ff <= csr_ch.wdata[ipnmf_pkg::WIDTH_REG_BITS-1:0];
            ipnmf_pkg::REG_HEIGHT: height_reg_ff <= csr_ch.wdata[HB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_raw = WW'(width_reg_ff);
      if (w_raw < WW'(2)) begin
         w_eff = WW'(2);
      end else if (w_raw > MAX_W) begin
         w_eff = MAX_W;
      end else begin
         w_eff = w_raw;
      end
      h_eff = (height_reg_ff < HB'(2)) ? HB'(2) : height_reg_ff;
      h_ext = RW'(h_eff);
   end

   // input side
   assign req_ch.ready = (state_ff == ST_IDLE) && !start_ff && !mean_busy;
   assign accept       = req_ch.valid && req_ch.ready;
   assign skip         = req_ch.drain && (in_row_ff < h_ext);
   assign blank        = req_ch.drain || (in_row_ff >= h_ext);
   assign loading      = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !skip) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && !skip) begin
         s_ff <= blank ? '0 : req_ch.sample;
      end
   end

   ipnmf_ram #(
      .WIDTH (2 * SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (loading),
      .wr_addr (in_col_ff),
      .wr_data ({mid_c, s_ff}),
      .rd_en   (accept && !skip),
      .rd_addr (in_col_ff),
      .rd_data (ram_rd_data)
   );

   assign top_c = ram_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign mid_c = ram_rd_data[SAMPLE_BITS-1:0];

   // scan counters, all advanced in the load cycle
   always_comb begin
      in_col_inc  = WW'(in_col_ff) + WW'(1);
      in_wrap     = in_col_inc >= w_eff;
      out_col_inc = WW'(out_col_ff) + WW'(1);
      out_wrap    = out_col_inc >= w_eff;
      out_row_inc = RW'(out_row_ff) + RW'(1);
      emit = ((in_row_ff >= RW'(2)) || (in_row_ff == RW'(1) && in_col_ff != '0)) &&
             (RW'(out_row_ff) < h_ext);

      border_c.top_ok   = (out_row_ff != '0);
      border_c.bot_ok   = (out_row_inc < h_ext);
      border_c.left_ok  = (out_col_ff != '0);
      border_c.right_ok = !out_wrap;
      border_c.last     = !border_c.bot_ok && out_wrap;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_row_n  = RW'(out_row_ff);
      if (loading) begin
         if (in_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_inc[CW-1:0];
         end
         if (emit) begin
            if (out_wrap) begin
               out_col_in = '0;
               out_row_n  = out_row_inc;
            end else begin
               out_col_in = out_col_inc[CW-1:0];
            end
         end
         out_row_in = out_row_n[HB-1:0];
         // frame finished (or height lowered): start over
         if (out_row_n >= h_ext) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
   end

   assign start_in = loading && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         start_ff   <= 1'b0;
         for (int i = 0; i < ipnmf_pkg::NUM_TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         start_ff   <= start_in;
         if (loading) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= top_c;
            win_ff[3] <= win_ff[4];
            win_ff[4] <= win_ff[5];
            win_ff[5] <= mid_c;
            win_ff[6] <= win_ff[7];
            win_ff[7] <= win_ff[8];
            win_ff[8] <= s_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (loading) begin
         border_ff <= border_c;
      end
   end

   // window stays put until the mean unit is idle again
   ipnmf_mean #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .win       (win_ff),
      .border    (border_ff),
      .threshold (thresh_ff),
      .busy      (mean_busy),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

@@ hdl/ipnmf_check.sv @@
// port-level checker for the neighbour mean fill block, bound to the top level
`default_nettype none

module ipnmf_check #(
   parameter int SAMPLE_BITS = 16
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   req_drain,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [SAMPLE_BITS-1:0] rsp_value,
   input wire logic                   rsp_replaced,
   input wire logic                   rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_value) && $stable(rsp_replaced) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // a pixel word always goes through the line store cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_drain |=> !req_ready)
      else $error("input taken during line store update");

   // a new result only comes out of the mean unit, which holds off input
   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without mean unit activity");

endmodule

bind invalid_pixel_neighbour_mean_fill ipnmf_check #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_ipnmf_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_drain    (req_ch.drain),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_value    (rsp_ch.filled_value),
   .rsp_replaced (rsp_ch.was_replaced),
   .rsp_last     (rsp_ch.frame_last)
);

`default_nettype wire

@@ dv/tb_invalid_pixel_neighbour_mean_fill.sv @@
// testbench for the neighbour mean fill block: directed and random frames against a predictor
module tb_invalid_pixel_neighbour_mean_fill;
   import ipnmf_pkg::*;

   localparam int MAXW         = 2048;
   localparam int PIX_BITS     = 16;
   localparam int SETTLE       = 12;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int RANDOM_WORDS = 1600;
   localparam int MAX_PRINTS   = 50;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [PIX_BITS-1:0] sample;
      logic                       drain;
   } pixel_word_t;

   typedef struct packed {
      logic signed [PIX_BITS-1:0] value;
      logic                       replaced;
      logic                       last;
   } fill_word_t;

   logic clock = 1'b0;
   logic reset;

   ipnmf_req_if #(.SAMPLE_BITS(PIX_BITS)) req_bus ();
   ipnmf_rsp_if #(.SAMPLE_BITS(PIX_BITS)) rsp_bus ();
   ipnmf_csr_if csr_bus ();

   invalid_pixel_neighbour_mean_fill #(
      .MAX_WIDTH   (MAXW),
      .SAMPLE_BITS (PIX_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #10 clock = ~clock;

   // predictor state
   logic signed [PIX_BITS-1:0] thr_reg;
   logic [WIDTH_REG_BITS-1:0]  width_reg;
   logic [HEIGHT_REG_BITS-1:0] height_reg;
   logic signed [PIX_BITS-1:0] line_mem [0:2*MAXW-1];
   logic signed [PIX_BITS-1:0] win_taps [0:8];
   int unsigned in_col, in_row, out_col, out_row;

   pixel_word_t pixels_to_send [$];
   fill_word_t  pending_fills [$];
   pixel_word_t cur_word;
   fill_word_t  oldest_fill;

   int n_words_in;
   int n_results;
   int n_csr_writes;
   int n_gen_words;
   int mismatch_count;
   int cycle_count;
   int send_gap;
   int stall_left;

   function automatic int unsigned eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > MAXW) return MAXW;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg < 2) ? 2 : height_reg;
   endfunction

   function automatic void clear_model();
      thr_reg    = 16'sh7FFF;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < 2 * MAXW; i++) line_mem[i] = '0;
      for (int i = 0; i < NUM_TAPS; i++) win_taps[i] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic void apply_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] d);
      case (idx)
         REG_THRESHOLD: thr_reg = d[PIX_BITS-1:0];
         REG_WIDTH:     width_reg = d[WIDTH_REG_BITS-1:0];
         REG_HEIGHT:    height_reg = d[HEIGHT_REG_BITS-1:0];
         default: ;
      endcase
   endfunction

   // advances the scan by one accepted word and queues the fill it releases, if any
   function automatic void predict_fill(input pixel_word_t pw);
      int unsigned wd, ht, col;
      logic signed [PIX_BITS-1:0] s, top, mid, ctr, v;
      bit emit;
      int sum, cnt;
      fill_word_t res;
      wd = eff_width();
      ht = eff_height();
      if (pw.drain && in_row < ht) return;
      s = (pw.drain || in_row >= ht) ? '0 : pw.sample;
      col = (in_col < MAXW) ? in_col : MAXW - 1;
      top = line_mem[MAXW + col];
      mid = line_mem[col];
      line_mem[MAXW + col] = mid;
      line_mem[col] = s;
      for (int r = 0; r < 3; r++) begin
         win_taps[r*3]   = win_taps[r*3+1];
         win_taps[r*3+1] = win_taps[r*3+2];
      end
      win_taps[2] = top;
      win_taps[5] = mid;
      win_taps[8] = s;
      emit = (in_row >= 2 || (in_row == 1 && in_col >= 1)) && out_row < ht;
      in_col++;
      if (in_col >= wd) begin
         in_col = 0;
         in_row++;
      end
      if (emit) begin
         ctr = win_taps[CENTRE_TAP];
         sum = 0;
         cnt = 0;
         for (int dr = -1; dr <= 1; dr++) begin
            if (dr < 0 && out_row == 0) continue;
            if (dr > 0 && out_row + 1 >= ht) continue;
            for (int dc = -1; dc <= 1; dc++) begin
               if (dr == 0 && dc == 0) continue;
               if (dc < 0 && out_col == 0) continue;
               if (dc > 0 && out_col + 1 >= wd) continue;
               v = win_taps[(1 + dr) * 3 + 1 + dc];
               if (v <= thr_reg) begin
                  sum += v;
                  cnt++;
               end
            end
         end
         res.value    = ctr;
         res.replaced = 1'b0;
         if (ctr > thr_reg && cnt > 0) begin
            // int division truncates toward zero
            res.value    = sum / cnt;
            res.replaced = 1'b1;
         end
         res.last = (out_row + 1 >= ht) && (out_col + 1 >= wd);
         pending_fills.push_back(res);
         out_col++;
         if (out_col >= wd) begin
            out_col = 0;
            out_row++;
         end
      end
      if (out_row >= ht) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 100);
   endfunction

   // half of the picks cluster around the threshold so both sides of it show up
   function automatic logic signed [PIX_BITS-1:0] rand_pixel();
      int t, u, v;
      logic [31:0] r;
      t = thr_reg;
      case ($urandom_range(0, 3))
         0: begin
            r = $urandom;
            return r[PIX_BITS-1:0];
         end
         1: begin
            u = $urandom_range(0, 40);
            v = t + 1 + u;
         end
         2: begin
            u = $urandom_range(0, 40);
            v = t - u;
         end
         default: begin
            u = $urandom_range(0, 600);
            v = u - 300;
         end
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[PIX_BITS-1:0];
   endfunction

   task automatic flag_mismatch(input string what, input logic signed [16:0] got,
                                input logic signed [16:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("result %0d: %s, got %0d want %0d", n_results, what, got, want);
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_fill(cur_word);
            n_words_in++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
               cur_word = pixels_to_send.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.sample <= cur_word.sample;
               req_bus.drain  <= cur_word.drain;
               send_gap = (((n_words_in / 200) % 3) == 1) ? 0 : pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            n_results++;
            if (pending_fills.size() == 0) begin
               flag_mismatch("result with nothing expected", rsp_bus.filled_value, 0);
            end else begin
               oldest_fill = pending_fills.pop_front();
               if (rsp_bus.filled_value !== oldest_fill.value)
                  flag_mismatch("filled_value", rsp_bus.filled_value, oldest_fill.value);
               if (rsp_bus.was_replaced !== oldest_fill.replaced)
                  flag_mismatch("was_replaced", rsp_bus.was_replaced, oldest_fill.replaced);
               if (rsp_bus.frame_last !== oldest_fill.last)
                  flag_mismatch("frame_last", rsp_bus.frame_last, oldest_fill.last);
            end
            // long hold-offs so the block backs up into its input
            if (n_results == 60) stall_left = 400;
            if (n_results == 4500) stall_left = 1200;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = (((n_results / 170) % 3) == 2) ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] d);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= d;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      apply_csr(idx, d);
      n_csr_writes++;
      @(negedge clock);
   endtask

   // upper data bits are don't-care, so they are randomized
   task automatic set_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] low);
      logic [CSR_DATA_BITS-1:0] d;
      d = $urandom;
      d[15:0] = low;
      csr_write(idx, d);
   endtask

   task automatic random_csr_write();
      logic [CSR_DATA_BITS-1:0] d;
      int pick;
      d = $urandom;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            if (pick < 8) d[15:0] = 16'h8000;
            else if (pick < 16) d[15:0] = 16'h7FFF;
            csr_write(REG_THRESHOLD, d);
         end
         3, 4, 5: begin
            if (pick < 10) d[WIDTH_REG_BITS-1:0] = $urandom_range(0, 1);
            else if (pick < 20) d[WIDTH_REG_BITS-1:0] = $urandom_range(10, 24);
            else d[WIDTH_REG_BITS-1:0] = $urandom_range(2, 9);
            csr_write(REG_WIDTH, d);
         end
         6, 7, 8: begin
            if (pick < 15) d[15:0] = $urandom_range(0, 1);
            else if (pick < 30) d[15:0] = $urandom_range(7, 10);
            else d[15:0] = $urandom_range(2, 6);
            csr_write(REG_HEIGHT, d);
         end
         default: csr_write(REG_UNUSED, d);
      endcase
   endtask

   task automatic push_word(input logic signed [PIX_BITS-1:0] s, input logic drn);
      pixel_word_t pw;
      pw.sample = s;
      pw.drain  = drn;
      pixels_to_send.push_back(pw);
   endtask

   // stray drains in the middle of a frame are ignored by the block
   task automatic push_pixels(input int count);
      logic [31:0] r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 32) == 0) begin
            r = $urandom;
            push_word(r[PIX_BITS-1:0], 1'b1);
         end
         push_word(rand_pixel(), 1'b0);
         n_gen_words++;
      end
   endtask

   // one row plus one word to flush; samples past the frame act as drains
   task automatic push_tail(input int w);
      logic [31:0] r;
      for (int i = 0; i <= w; i++) begin
         r = $urandom;
         push_word(r[PIX_BITS-1:0], $urandom_range(0, 3) != 0);
         n_gen_words++;
      end
      repeat ($urandom_range(0, 2)) begin
         r = $urandom;
         push_word(r[PIX_BITS-1:0], 1'b1);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pixels_to_send.size() != 0 || req_bus.valid || pending_fills.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      int w, h, k;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      req_bus.drain  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = REG_THRESHOLD;
      csr_bus.wdata  = '0;
      rsp_bus.ready  = 1'b0;
      reset = 1'b1;
      n_words_in = 0;
      n_results = 0;
      n_csr_writes = 0;
      n_gen_words = 0;
      mismatch_count = 0;
      cycle_count = 0;
      clear_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 3x3 frame: corners, edges, centre, extremes, exact threshold
      set_reg(REG_THRESHOLD, 16'd100);
      set_reg(REG_WIDTH, 16'd3);
      set_reg(REG_HEIGHT, 16'd3);
      set_reg(REG_UNUSED, 16'h5A5A);
      push_word(32767, 1'b0);
      push_word(-32768, 1'b0);
      push_word(200, 1'b0);
      push_word(-32768, 1'b0);
      push_word(-1, 1'b1);
      push_word(32767, 1'b0);
      push_word(-5, 1'b0);
      push_word(101, 1'b0);
      push_word(100, 1'b0);
      push_word(150, 1'b0);
      push_word(0, 1'b1);
      push_word(7, 1'b0);
      push_word(-1, 1'b1);
      push_word(-9, 1'b0);
      push_word(3, 1'b1);
      wait_idle();

      // width and height below range clamp to 2; nothing valid so pixels are kept
      set_reg(REG_THRESHOLD, 16'h8000);
      set_reg(REG_WIDTH, 16'd1);
      set_reg(REG_HEIGHT, 16'd1);
      push_word(5, 1'b0);
      push_word(32767, 1'b0);
      push_word(-1, 1'b0);
      push_word(0, 1'b0);
      push_word(0, 1'b1);
      push_word(0, 1'b1);
      push_word(0, 1'b1);
      wait_idle();

      // widest row: width register above range acts as the maximum
      set_reg(REG_THRESHOLD, 16'd1000);
      set_reg(REG_WIDTH, 16'h0FFF);
      set_reg(REG_HEIGHT, 16'd2);
      push_pixels(eff_width() * eff_height());
      push_tail(eff_width());
      wait_idle();

      // tallest frame cut short mid-frame, threshold changed on the way
      set_reg(REG_THRESHOLD, 16'h7FFF);
      set_reg(REG_WIDTH, 16'd5);
      set_reg(REG_HEIGHT, 16'hFFFF);
      push_pixels(15);
      wait_idle();
      set_reg(REG_THRESHOLD, -16'sd100);
      set_reg(REG_HEIGHT, 16'd2);
      push_tail(5);
      wait_idle();

      // height lowered below the output row: next word clears the counters
      set_reg(REG_THRESHOLD, 16'd0);
      set_reg(REG_WIDTH, 16'd4);
      set_reg(REG_HEIGHT, 16'hFFFF);
      push_pixels(16);
      wait_idle();
      set_reg(REG_HEIGHT, 16'd0);
      push_word(0, 1'b1);
      push_pixels(8);
      push_tail(4);
      wait_idle();

      n_gen_words = 0;
      while (n_gen_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 1) == 1) begin
            wait_idle();
            repeat ($urandom_range(1, 3)) random_csr_write();
         end
         w = eff_width();
         h = eff_height();
         if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(1, w * h - 1);
            push_pixels(k);
            wait_idle();
            set_reg(REG_THRESHOLD, rand_pixel());
            push_pixels(w * h - k);
         end else begin
            push_pixels(w * h);
         end
         push_tail(w);
      end

      wait_idle();
      repeat (20) @(negedge clock);
      if (pending_fills.size() != 0)
         flag_mismatch("results never produced", pending_fills.size(), 0);
      $display("sent %0d words over frames from 2x2 to 2048 wide, %0d register writes",
               n_words_in, n_csr_writes);
      $display("checked %0d results, %0d mismatches", n_results, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/ipnmf_pkg.sv
hdl/ipnmf_ifs.sv
hdl/ipnmf_ram.sv
hdl/ipnmf_mean.sv
hdl/invalid_pixel_neighbour_mean_fill.sv
hdl/ipnmf_check.sv
dv/tb_invalid_pixel_neighbour_mean_fill.sv
